// File: sv/lpf_pkg.sv
// Shared types and constants for the loopback TCP port filter.
// No dependencies; imported by the parser, queue, judge, top level and checker.
`default_nettype none

package lpf_pkg;

	// Register reset values
	localparam logic [15:0] MATCH_PORT_RESET    = 16'd8000;
	localparam logic [31:0] NET_PREFIX_RESET    = 32'h7F00_0000;
	localparam logic [31:0] NET_MASK_RESET      = 32'hFF00_0000;
	localparam logic [7:0]  CAPTURE_LIMIT_RESET = 8'd128;

	localparam int CAPTURE_MAX_DEFAULT = 128;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  IP_PROTO_TCP    = 8'd6;
	localparam logic [3:0]  MIN_HDR_WORDS   = 4'd5;
	localparam int          CFG_INDEX_W     = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MATCH_PORT    = 2'd0,
		CFG_NET_PREFIX    = 2'd1,
		CFG_NET_MASK      = 2'd2,
		CFG_CAPTURE_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		VERDICT_ACCEPT     = 4'd0,
		VERDICT_TRUNCATED  = 4'd1,
		VERDICT_NOT_IPV4   = 4'd2,
		VERDICT_NOT_TCP    = 4'd3,
		VERDICT_BAD_IHL    = 4'd4,
		VERDICT_OFF_PREFIX = 4'd5,
		VERDICT_PORT       = 4'd6,
		VERDICT_BAD_DOFF   = 4'd7,
		VERDICT_NO_PAYLOAD = 4'd8
	} verdict_t;

	typedef struct packed {
		logic [15:0] match_port;
		logic [31:0] net_prefix;
		logic [31:0] net_mask;
		logic [7:0]  capture_limit;
	} cfg_t;

	// Header fields of one finished frame, handed from the parser to the judge.
	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] ether_type;
		logic [3:0]  ip_header_words;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] ip_total_length;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [3:0]  tcp_header_words;
	} frame_summary_t;

endpackage

`default_nettype wire

// File: sv/lpf_frame_if.sv
// Byte stream channel carrying Ethernet frames into the filter.
// Depends on nothing; valid/ready handshake with a source and a sink modport.
`default_nettype none

interface lpf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

`default_nettype wire

// File: sv/lpf_result_if.sv
// Result channel carrying one verdict per frame out of the filter.
// Depends on nothing; valid/ready handshake with a source and a sink modport.
`default_nettype none

interface lpf_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  verdict;
	logic [15:0] remote_port;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;
	logic [7:0]  capture_length;
	logic [15:0] frame_length;

	modport source (
		output valid, output verdict, output remote_port, output payload_offset,
		output payload_length, output capture_length, output frame_length,
		input ready
	);
	modport sink (
		input valid, input verdict, input remote_port, input payload_offset,
		input payload_length, input capture_length, input frame_length,
		output ready
	);
endinterface

`default_nettype wire

// File: sv/lpf_front.sv
// Byte parser: counts frame bytes and captures the Ethernet, IPv4 and TCP fields.
// Depends on lpf_pkg; pushes one frame summary per last byte into the queue.
`default_nettype none

module lpf_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    byte_valid,
	input  wire logic [7:0]              frame_byte,
	input  wire logic                    frame_last,
	input  wire logic                    queue_full,
	output logic                         byte_ready,
	output logic                         push,
	output lpf_pkg::frame_summary_t      push_data
);
	import lpf_pkg::*;

	localparam logic [15:0] POS_ETYPE_HI = 16'd12;
	localparam logic [15:0] POS_ETYPE_LO = 16'd13;
	localparam logic [15:0] POS_IHL      = 16'd14;
	localparam logic [15:0] POS_TLEN_HI  = 16'd16;
	localparam logic [15:0] POS_TLEN_LO  = 16'd17;
	localparam logic [15:0] POS_PROTO    = 16'd23;
	localparam logic [15:0] POS_SADDR    = 16'd26;
	localparam logic [15:0] POS_DADDR    = 16'd30;
	localparam logic [6:0]  ETH_HDR_LEN  = 7'd14;

	logic [15:0]    count_q;
	frame_summary_t fld_q;
	frame_summary_t fld_next;
	logic           accept;
	logic           active;
	logic [6:0]     tcp_start;
	logic [15:0]    rel;

	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;
	assign active     = (count_q != '1);

	always_comb begin
		fld_next = fld_q;
		fld_next.frame_length = count_q;
		tcp_start = ETH_HDR_LEN;
		rel = '0;
		if (active) begin
			fld_next.frame_length = count_q + 16'd1;
			if (count_q == POS_ETYPE_HI) fld_next.ether_type[15:8] = frame_byte;
			if (count_q == POS_ETYPE_LO) fld_next.ether_type[7:0] = frame_byte;
			if (count_q == POS_IHL) fld_next.ip_header_words = frame_byte[3:0];
			if (count_q == POS_TLEN_HI) fld_next.ip_total_length[15:8] = frame_byte;
			if (count_q == POS_TLEN_LO) fld_next.ip_total_length[7:0] = frame_byte;
			if (count_q == POS_PROTO) fld_next.ip_protocol = frame_byte;
			if (count_q >= POS_SADDR && count_q < POS_DADDR)
				fld_next.source_address = {fld_q.source_address[23:0], frame_byte};
			if (count_q >= POS_DADDR && count_q < POS_DADDR + 16'd4)
				fld_next.dest_address = {fld_q.dest_address[23:0], frame_byte};
			// The TCP header position uses the header length written by this very byte.
			tcp_start = ETH_HDR_LEN + {1'b0, fld_next.ip_header_words, 2'b00};
			rel = count_q - {9'd0, tcp_start};
			if (rel == 16'd0) fld_next.source_port[15:8] = frame_byte;
			if (rel == 16'd1) fld_next.source_port[7:0] = frame_byte;
			if (rel == 16'd2) fld_next.dest_port[15:8] = frame_byte;
			if (rel == 16'd3) fld_next.dest_port[7:0] = frame_byte;
			if (rel == 16'd12) fld_next.tcp_header_words = frame_byte[7:4];
		end
	end

	assign push      = accept && frame_last;
	assign push_data = fld_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fld_q   <= '0;
		end else if (accept) begin
			if (frame_last) begin
				count_q <= '0;
				fld_q   <= '0;
			end else begin
				count_q <= fld_next.frame_length;
				fld_q   <= fld_next;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/lpf_queue.sv
// Short queue of frame summaries between the byte parser and the judge.
// Depends on lpf_pkg for the summary type; first word falls through on head.
`default_nettype none

module lpf_queue #(
	parameter int DEPTH = lpf_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire lpf_pkg::frame_summary_t push_data,
	input  wire logic                    pop,
	output logic                         full,
	output logic                         head_valid,
	output lpf_pkg::frame_summary_t      head
);
	import lpf_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_summary_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: sv/lpf_back.sv
// Judge: checks one frame summary against the configuration and forms the result.
// Depends on lpf_pkg and lpf_result_if; the result is held in an output register.
`default_nettype none

module lpf_back #(
	parameter int CAPTURE_MAX = lpf_pkg::CAPTURE_MAX_DEFAULT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lpf_pkg::cfg_t           cfg,
	input  wire logic                    head_valid,
	input  wire lpf_pkg::frame_summary_t head,
	output logic                         pop,
	lpf_result_if.source                 result
);
	import lpf_pkg::*;

	localparam int CM_W  = $clog2(CAPTURE_MAX + 1);
	localparam int LIM_W = (CM_W > 8) ? CM_W : 8;
	localparam logic [LIM_W-1:0] CAP_MAX = LIM_W'(CAPTURE_MAX);

	logic        valid_q;
	verdict_t    verdict_q;
	logic [15:0] peer_q;
	logic [15:0] poff_q;
	logic [15:0] plen_q;
	logic [7:0]  cap_q;
	logic [15:0] flen_q;

	logic [5:0]       ihl_bytes;
	logic [5:0]       doff_bytes;
	logic [6:0]       tcp_need;
	logic [7:0]       poff;
	logic [16:0]      plen_ext;
	logic             plen_bad;
	logic [LIM_W-1:0] cfg_lim;
	logic [LIM_W-1:0] lim;
	logic [15:0]      cap_wide;
	logic             prefix_ok;
	verdict_t         verdict;

	assign ihl_bytes  = {head.ip_header_words, 2'b00};
	assign doff_bytes = {head.tcp_header_words, 2'b00};
	assign tcp_need   = 7'd34 + {1'b0, ihl_bytes};
	assign poff       = 8'd14 + {2'b00, ihl_bytes} + {2'b00, doff_bytes};
	assign plen_ext   = {1'b0, head.ip_total_length} - {11'd0, ihl_bytes}
		- {11'd0, doff_bytes};
	// Negative or zero payload length both count as no payload.
	assign plen_bad   = plen_ext[16] || (plen_ext[15:0] == '0);
	assign prefix_ok  = ((head.source_address & cfg.net_mask) == cfg.net_prefix)
		&& ((head.dest_address & cfg.net_mask) == cfg.net_prefix);
	assign cfg_lim    = LIM_W'(cfg.capture_limit);
	assign lim        = (cfg_lim < CAP_MAX) ? cfg_lim : CAP_MAX;
	assign cap_wide   = (plen_ext[15:0] < 16'(lim)) ? plen_ext[15:0] : 16'(lim);

	always_comb begin
		if (head.frame_length < 16'd14) verdict = VERDICT_TRUNCATED;
		else if (head.ether_type != ETHERTYPE_IPV4) verdict = VERDICT_NOT_IPV4;
		else if (head.frame_length < 16'd34) verdict = VERDICT_TRUNCATED;
		else if (head.ip_protocol != IP_PROTO_TCP) verdict = VERDICT_NOT_TCP;
		else if (head.ip_header_words < MIN_HDR_WORDS) verdict = VERDICT_BAD_IHL;
		else if (head.frame_length < {9'd0, tcp_need}) verdict = VERDICT_TRUNCATED;
		else if (!prefix_ok) verdict = VERDICT_OFF_PREFIX;
		else if (head.source_port != cfg.match_port && head.dest_port != cfg.match_port)
			verdict = VERDICT_PORT;
		else if (head.tcp_header_words < MIN_HDR_WORDS) verdict = VERDICT_BAD_DOFF;
		else if ({8'd0, poff} >= head.frame_length) verdict = VERDICT_NO_PAYLOAD;
		else if (plen_bad) verdict = VERDICT_NO_PAYLOAD;
		else verdict = VERDICT_ACCEPT;
	end

	assign pop = head_valid && (!valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= verdict;
			flen_q    <= head.frame_length;
			if (verdict == VERDICT_ACCEPT) begin
				peer_q <= (head.dest_port == cfg.match_port) ? head.source_port
					: head.dest_port;
				poff_q <= {8'd0, poff};
				plen_q <= plen_ext[15:0];
				cap_q  <= cap_wide[7:0];
			end else begin
				peer_q <= '0;
				poff_q <= '0;
				plen_q <= '0;
				cap_q  <= '0;
			end
		end
	end

	assign result.valid          = valid_q;
	assign result.verdict        = verdict_q;
	assign result.remote_port    = peer_q;
	assign result.payload_offset = poff_q;
	assign result.payload_length = plen_q;
	assign result.capture_length = cap_q;
	assign result.frame_length   = flen_q;

endmodule

`default_nettype wire

// File: sv/loopback_tcp_port_filter.sv
// Loopback TCP port filter. Frames enter one byte per request, and one byte is
// taken every clock cycle for as long as the frame summary queue has room. The
// byte parser captures the header fields as they pass; on the last byte it
// queues a summary of the frame, and the judge turns the oldest summary into a
// registered result. The judge delivers at most one result per cycle, so the
// summary queue (four entries by default) absorbs stalls on the result side:
// byte intake pauses only when it is full. The user must write registers through
// the plain write port while no frame is in flight; the block does not enforce it.
// Depends on lpf_pkg, lpf_frame_if, lpf_result_if, lpf_front, lpf_queue, lpf_back.
`default_nettype none

module loopback_tcp_port_filter #(
	parameter int CAPTURE_MAX = lpf_pkg::CAPTURE_MAX_DEFAULT,
	parameter int QUEUE_DEPTH = lpf_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [lpf_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [31:0]                     wr_data,
	lpf_frame_if.sink                            frame,
	lpf_result_if.source                         result
);
	import lpf_pkg::*;

	cfg_t           cfg_q;
	logic           queue_full;
	logic           push;
	frame_summary_t push_data;
	logic           pop;
	logic           head_valid;
	frame_summary_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_port    <= MATCH_PORT_RESET;
			cfg_q.net_prefix    <= NET_PREFIX_RESET;
			cfg_q.net_mask      <= NET_MASK_RESET;
			cfg_q.capture_limit <= CAPTURE_LIMIT_RESET;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				CFG_MATCH_PORT:    cfg_q.match_port    <= wr_data[15:0];
				CFG_NET_PREFIX:    cfg_q.net_prefix    <= wr_data;
				CFG_NET_MASK:      cfg_q.net_mask      <= wr_data;
				CFG_CAPTURE_LIMIT: cfg_q.capture_limit <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	lpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (frame.valid),
		.frame_byte (frame.frame_byte),
		.frame_last (frame.frame_last),
		.queue_full (queue_full),
		.byte_ready (frame.ready),
		.push       (push),
		.push_data  (push_data)
	);

	lpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head)
	);

	lpf_back #(
		.CAPTURE_MAX (CAPTURE_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire

// File: sv/lpf_checker.sv
// Port-level checks on the result channel of the loopback TCP port filter.
// Depends on lpf_pkg for the verdict codes; bound to the top level below.
`default_nettype none

module lpf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [3:0]  verdict,
	input wire logic [15:0] remote_port,
	input wire logic [15:0] payload_offset,
	input wire logic [15:0] payload_length,
	input wire logic [7:0]  capture_length,
	input wire logic [15:0] frame_length
);
	import lpf_pkg::*;

	// A rejected frame reports nothing about its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && verdict != VERDICT_ACCEPT |->
			remote_port == '0 && payload_offset == '0 && payload_length == '0
			&& capture_length == '0)
		else $error("rejected frame carries payload fields");

	// An accepted frame has a payload inside the frame and a capture within it.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid && verdict == VERDICT_ACCEPT |->
			payload_length != '0 && payload_offset < frame_length
			&& {8'd0, capture_length} <= payload_length)
		else $error("accepted frame with inconsistent payload fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> verdict <= VERDICT_NO_PAYLOAD)
		else $error("verdict code out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(verdict) && $stable(frame_length)
			&& $stable(remote_port))
		else $error("stalled result changed");

endmodule

bind loopback_tcp_port_filter lpf_checker u_lpf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (result.valid),
	.ready          (result.ready),
	.verdict        (result.verdict),
	.remote_port    (result.remote_port),
	.payload_offset (result.payload_offset),
	.payload_length (result.payload_length),
	.capture_length (result.capture_length),
	.frame_length   (result.frame_length)
);

`default_nettype wire
